// ===== src/dcsp_pkg.sv =====
// package: types, constants and helpers of the cnf stream parser
`default_nettype none
package dcsp_pkg;
   localparam int VAR_BITS = 20;
   localparam int CLAUSE_COUNT_BITS = 24;
   localparam int MAG_BITS = 32;

   typedef enum logic [2:0] {
      EV_HEADER = 3'd0, EV_LITERAL = 3'd1, EV_CLAUSE_END = 3'd2,
      EV_DONE = 3'd3, EV_ERROR = 3'd4
   } event_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0, ERR_STRAY = 3'd1, ERR_HEADER = 3'd2, ERR_TOKEN = 3'd3,
      ERR_END = 3'd4, ERR_RANGE = 3'd5
   } error_code_type;

   typedef enum logic [2:0] {
      PH_LINE_START, PH_BLANK_LINE, PH_COMMENT, PH_HEADER, PH_CLAUSES
   } phase_type;

   localparam logic [7:0] CH_C = 8'h63;
   localparam logic [7:0] CH_P = 8'h70;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO = 8'h30;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } item_type;

   typedef struct packed {
      event_kind_type            kind;
      logic [VAR_BITS:0]         lit;
      logic [VAR_BITS-1:0]       vars;
      logic [CLAUSE_COUNT_BITS-1:0] cls;
      error_code_type            err;
      logic                      last;
   } event_type;

   typedef struct packed {
      logic      [1:0] count;
      event_type [1:0] ev;
   } bundle_type;

   function automatic logic is_ws(input logic [7:0] ch);
      return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
   endfunction

   function automatic event_type mk(input event_kind_type k, input logic [VAR_BITS:0] l,
                                    input logic [VAR_BITS-1:0] v,
                                    input logic [CLAUSE_COUNT_BITS-1:0] c,
                                    input error_code_type e);
      event_type r;
      r.kind = k; r.lit = l; r.vars = v; r.cls = c; r.err = e; r.last = 1'b0;
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== src/dimacs_cnf_stream_parser_unit.sv =====
// top level of the dimacs cnf stream parser
// usage:
//  req_ channel carries one text byte per transfer, req_tuser flags end of input
//  rsp_ channel carries one event per transfer, rsp_tlast marks the last
//  event caused by one input transfer (one input gives zero, one or two events)
//  an input is accepted every cycle while the result queue has room;
//  an input's first event passes the front bundle register, then the back queue
//  two-event inputs go out as two transfers, so sustained rate is one byte per
//  cycle except where the output serialiser is busy with a second event
//  a stalled receiver fills the two-entry queue and the front bundle register, then req_tready drops
//  after reset the parser waits for the header; after done or an error all
//  further input is accepted and dropped until reset
//  reset is synchronous and clears all control state
`default_nettype none
module dimacs_cnf_stream_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // text_byte
   input  wire logic        req_tuser,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // event_kind, literal_value, declared_vars,
                                         // declared_clauses, error_code, zero fill
   output logic             rsp_tlast
);
   import dcsp_pkg::*;

   item_type item;
   logic mid_valid, mid_ready;
   bundle_type mid_bundle;
   event_type ev;

   assign item.ch = req_tdata;
   assign item.eoi = req_tuser;

   dcsp_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(item),
      .out_valid(mid_valid), .out_ready(mid_ready), .out_bundle(mid_bundle)
   );

   dcsp_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(mid_valid), .in_ready(mid_ready), .in_bundle(mid_bundle),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_event(ev)
   );

   assign rsp_tdata = {1'b0, ev.err, ev.cls, ev.vars, ev.lit, ev.kind};
   assign rsp_tlast = ev.last;
endmodule
`default_nettype wire

// ===== src/dcsp_front.sv =====
// front: byte parser that turns each transfer into a bundle of up to two events
`default_nettype none
module dcsp_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire dcsp_pkg::item_type in_item,
   output logic      out_valid,
   input  wire logic out_ready,
   output dcsp_pkg::bundle_type out_bundle
);
   import dcsp_pkg::*;

   phase_type phase_ff, phase_in;
   logic [2:0] hfi_ff, hfi_in;
   logic [1:0] kmp_ff, kmp_in;
   logic [MAG_BITS-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in, dig_ff, dig_in, open_ff, open_in;
   logic [VAR_BITS-1:0] vl_ff, vl_in;
   logic [CLAUSE_COUNT_BITS-1:0] cl_ff, cl_in;
   logic halt_ff, halt_in;
   logic valid_ff;
   bundle_type bun_ff, bun_in;

   logic take;
   assign in_ready = !valid_ff || out_ready;
   assign take = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_bundle = bun_ff;

   always_comb begin
      logic [7:0] ch;
      logic eoi, ws, le, isdig;
      logic [MAG_BITS+3:0] prod;
      logic [MAG_BITS-1:0] m;
      logic [1:0] n;
      logic [CLAUSE_COUNT_BITS-1:0] bound_c;
      event_type e0, e1;
      logic fld_ok, t_neg;
      logic [MAG_BITS-1:0] t_mag;
      ch = in_item.ch;
      eoi = in_item.eoi;
      ws = eoi || is_ws(ch);
      le = eoi || ch == CH_NL;
      isdig = ch >= 8'h30 && ch <= 8'h39;
      prod = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0} + {32'd0, ch[3:0]};
      m = (prod[MAG_BITS+3:MAG_BITS] != 4'd0) ? '1 : prod[MAG_BITS-1:0];
      phase_in = phase_ff; hfi_in = hfi_ff; kmp_in = kmp_ff; mag_in = mag_ff;
      neg_in = neg_ff; dig_in = dig_ff; open_in = open_ff;
      vl_in = vl_ff; cl_in = cl_ff; halt_in = halt_ff;
      n = 2'd0; fld_ok = 1'b0; bound_c = '0; t_neg = 1'b0; t_mag = '0;
      e0 = mk(EV_ERROR, '0, '0, '0, ERR_NONE); e1 = e0;
      if (!halt_ff) begin
         case (phase_ff)
            PH_LINE_START: begin
               if (eoi) begin n = 2'd1; e0.err = ERR_END; halt_in = 1'b1; end
               else if (ch == CH_C) phase_in = PH_COMMENT;
               else if (ch == CH_P) begin
                  phase_in = PH_HEADER; hfi_in = '0; kmp_in = '0;
                  mag_in = '0; neg_in = 0; dig_in = 0; open_in = 0;
               end else if (ch == CH_NL) phase_in = PH_LINE_START;
               else if (is_ws(ch)) phase_in = PH_BLANK_LINE;
               else begin n = 2'd1; e0.err = ERR_STRAY; halt_in = 1'b1; end
            end
            PH_BLANK_LINE: begin
               if (eoi) begin n = 2'd1; e0.err = ERR_END; halt_in = 1'b1; end
               else if (ch == CH_NL) phase_in = PH_LINE_START;
               else if (!is_ws(ch)) begin n = 2'd1; e0.err = ERR_STRAY; halt_in = 1'b1; end
            end
            PH_COMMENT: begin
               if (eoi) begin n = 2'd1; e0.err = ERR_END; halt_in = 1'b1; end
               else if (ch == CH_NL) phase_in = PH_LINE_START;
            end
            PH_HEADER: begin
               case (hfi_ff)
                  3'd0: begin
                     if (le || !ws) begin n = 2'd1; e0.err = ERR_HEADER; halt_in = 1'b1; end
                     else hfi_in = 3'd1;
                  end
                  3'd1: begin
                     if (le) begin n = 2'd1; e0.err = ERR_HEADER; halt_in = 1'b1; end
                     else if (kmp_ff == 2'd3) begin
                        if (!ws) begin n = 2'd1; e0.err = ERR_HEADER; halt_in = 1'b1; end
                        else hfi_in = 3'd2;
                     end else if (kmp_ff == 2'd0 && ws) begin
                     end else if (ch == (kmp_ff == 2'd0 ? CH_C : kmp_ff == 2'd1 ? CH_N : CH_F))
                        kmp_in = kmp_ff + 2'd1;
                     else begin n = 2'd1; e0.err = ERR_HEADER; halt_in = 1'b1; end
                  end
                  3'd2, 3'd3: begin
                     if (open_ff && ws) begin
                        if (hfi_ff == 3'd2)
                           fld_ok = mag_ff <= MAG_BITS'((64'd1 << VAR_BITS) - 1);
                        else
                           fld_ok = mag_ff <= MAG_BITS'((64'd1 << CLAUSE_COUNT_BITS) - 1);
                        if (!dig_ff || (neg_ff && mag_ff != '0) || !fld_ok) begin
                           n = 2'd1; e0.err = ERR_HEADER; halt_in = 1'b1;
                        end else begin
                           if (hfi_ff == 3'd2) vl_in = mag_ff[VAR_BITS-1:0];
                           else cl_in = mag_ff[CLAUSE_COUNT_BITS-1:0];
                           mag_in = '0; neg_in = 0; dig_in = 0; open_in = 0;
                           hfi_in = hfi_ff + 3'd1;
                           if (le) begin
                              if (hfi_ff == 3'd3) begin
                                 bound_c = mag_ff[CLAUSE_COUNT_BITS-1:0];
                                 phase_in = PH_CLAUSES; n = 2'd1;
                                 e0 = mk(EV_HEADER, '0, vl_ff, bound_c, ERR_NONE);
                                 if (bound_c == '0) begin
                                    n = 2'd2; e1.kind = EV_DONE; halt_in = 1'b1;
                                 end else if (eoi) begin
                                    n = 2'd2; e1.err = ERR_END; halt_in = 1'b1;
                                 end
                              end else begin
                                 n = 2'd1; e0.err = ERR_HEADER; halt_in = 1'b1;
                              end
                           end
                        end
                     end else if (le) begin n = 2'd1; e0.err = ERR_HEADER; halt_in = 1'b1; end
                     else if (ws) begin
                     end else if (isdig) begin
                        open_in = 1; dig_in = 1; mag_in = m;
                     end else if ((ch == CH_PLUS || ch == CH_MINUS) && !open_ff) begin
                        open_in = 1; neg_in = ch == CH_MINUS;
                     end else begin n = 2'd1; e0.err = ERR_HEADER; halt_in = 1'b1; end
                  end
                  default: begin
                     if (le) begin
                        phase_in = PH_CLAUSES; n = 2'd1;
                        e0 = mk(EV_HEADER, '0, vl_ff, cl_ff, ERR_NONE);
                        mag_in = '0; neg_in = 0; dig_in = 0; open_in = 0;
                        if (cl_ff == '0) begin
                           n = 2'd2; e1.kind = EV_DONE; halt_in = 1'b1;
                        end else if (eoi) begin
                           n = 2'd2; e1.err = ERR_END; halt_in = 1'b1;
                        end
                     end else if (!ws) begin n = 2'd1; e0.err = ERR_HEADER; halt_in = 1'b1; end
                  end
               endcase
            end
            default: begin
               if (ws) begin
                  if (open_ff) begin
                     t_mag = mag_ff; t_neg = neg_ff;
                     mag_in = '0; neg_in = 0; dig_in = 0; open_in = 0;
                     n = 2'd1;
                     if (!dig_ff) begin e0.err = ERR_TOKEN; halt_in = 1'b1; end
                     else if (t_mag == '0) begin
                        e0.kind = EV_CLAUSE_END;
                        cl_in = cl_ff - CLAUSE_COUNT_BITS'(1);
                        if (cl_ff == CLAUSE_COUNT_BITS'(1)) begin
                           n = 2'd2; e1.kind = EV_DONE; halt_in = 1'b1;
                        end
                     end else if (t_mag > MAG_BITS'(vl_ff)) begin
                        e0.err = ERR_RANGE; halt_in = 1'b1;
                     end else begin
                        e0.kind = EV_LITERAL;
                        e0.lit = t_neg ? -{1'b0, t_mag[VAR_BITS-1:0]} : {1'b0, t_mag[VAR_BITS-1:0]};
                     end
                  end
                  if (eoi && !halt_in) begin
                     if (n == 2'd0) begin n = 2'd1; e0.err = ERR_END; end
                     else begin n = 2'd2; e1.err = ERR_END; end
                     halt_in = 1'b1;
                  end
               end else if (isdig) begin
                  open_in = 1; dig_in = 1; mag_in = m;
               end else if ((ch == CH_PLUS || ch == CH_MINUS) && !open_ff) begin
                  open_in = 1; neg_in = ch == CH_MINUS;
               end else begin n = 2'd1; e0.err = ERR_TOKEN; halt_in = 1'b1; end
            end
         endcase
      end
      if (n == 2'd1) e0.last = 1'b1;
      if (n == 2'd2) e1.last = 1'b1;
      bun_in.count = n;
      bun_in.ev[0] = e0;
      bun_in.ev[1] = e1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE_START; hfi_ff <= '0; kmp_ff <= '0; mag_ff <= '0;
         neg_ff <= 0; dig_ff <= 0; open_ff <= 0; vl_ff <= '0;
         cl_ff <= '0; halt_ff <= 0; valid_ff <= 0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; hfi_ff <= hfi_in; kmp_ff <= kmp_in; mag_ff <= mag_in;
            neg_ff <= neg_in; dig_ff <= dig_in; open_ff <= open_in;
            vl_ff <= vl_in; cl_ff <= cl_in; halt_ff <= halt_in;
         end
         if (take) valid_ff <= bun_in.count != 2'd0;
         else if (out_ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) bun_ff <= bun_in;
   end

`ifndef SYNTH
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> bun_ff.count != 2'd0) else $error("empty bundle held");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt cleared");
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (halt_ff && take) |=> !valid_ff) else $error("output after halt");
`endif
endmodule
`default_nettype wire

// ===== src/dcsp_back.sv =====
// back: short bundle queue and serialiser onto the result stream
`default_nettype none
module dcsp_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire dcsp_pkg::bundle_type in_bundle,
   output logic      out_valid,
   input  wire logic out_ready,
   output dcsp_pkg::event_type out_event
);
   import dcsp_pkg::*;

   bundle_type q_ff [2];
   logic wp_ff, rp_ff, sel_ff;
   logic [1:0] cnt_ff;
   logic push, pop, fire;
   bundle_type head;

   assign head = q_ff[rp_ff];
   assign in_ready = cnt_ff != 2'd2;
   assign push = in_valid && in_ready;
   assign out_valid = cnt_ff != 2'd0;
   assign out_event = head.ev[sel_ff];
   assign fire = out_valid && out_ready;
   assign pop = fire && (sel_ff || head.count == 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 0; rp_ff <= 0; sel_ff <= 0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) begin rp_ff <= !rp_ff; sel_ff <= 0; end
         else if (fire) sel_ff <= 1'b1;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= in_bundle;
   end

`ifndef SYNTH
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue overflow");
   a_last_pop: assert property (@(posedge clock) disable iff (reset)
      fire |-> (out_event.last == pop)) else $error("last flag out of step");
   a_sel: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (out_valid && head.count == 2'd2)) else $error("bad second select");
`endif
endmodule
`default_nettype wire
